// ===== hdl/nca_pkg.sv =====
// Shared types and constants of the nearest centroid assigner.
`timescale 1ns / 1ps

package nca_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_LENGTH_DEF   = 64;

    localparam int FEAT_W = 16;
    localparam int VNUM_W = 16;
    localparam int DIST_W = 40;
    localparam int CIDX_W = 4;
    localparam int SQ_W   = 32;

    localparam int CLUSTER_COUNT_W = 5;
    localparam int VECTOR_LENGTH_W = 7;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_LENGTH = 1'b1;

    localparam logic [CLUSTER_COUNT_W-1:0] CLUSTER_COUNT_RST = 5'd2;
    localparam logic [VECTOR_LENGTH_W-1:0] VECTOR_LENGTH_RST = 7'd8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_value;
        logic                     start_set;
    } item_t;

    typedef struct packed {
        logic [CIDX_W-1:0] cluster_index;
        logic [VNUM_W-1:0] vector_number;
        logic [DIST_W-1:0] distance_squared;
    } result_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic                     store;
        logic signed [FEAT_W-1:0] feature;
        logic [VNUM_W-1:0]        vnum;
        logic [DIST_W-1:0]        best_d;
    } token_t;

endpackage

// ===== hdl/nca_ram.sv =====
// Generic single-port RAM with registered read and read enable.
`timescale 1ns / 1ps

module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hdl/nca_head.sv =====
// Input stage: element and vector counting, centroid loading decisions, configuration.
`timescale 1ns / 1ps

module nca_head
    import nca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
    localparam int CW = $clog2(MAX_CLUSTERS + 1),
    localparam int IW = $clog2(MAX_CLUSTERS),
    localparam int LW = $clog2(MAX_LENGTH + 1),
    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   item_valid,
    input  item_t                  item,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data,
    output token_t                 tok,
    output logic [PW-1:0]          pos,
    output logic [IW-1:0]          sidx,
    output logic [CW-1:0]          accn,
    output logic [CW-1:0]          candn
);

    logic [CLUSTER_COUNT_W-1:0] cluster_count_reg;
    logic [VECTOR_LENGTH_W-1:0] vector_length_reg;
    logic [PW-1:0]              position_reg, position_next;
    logic [VNUM_W-1:0]          count_reg, count_next;
    logic [CW-1:0]              loaded_reg, loaded_next;

    token_t        tok_reg, tok_next;
    logic [PW-1:0] pos_reg;
    logic [IW-1:0] sidx_reg;
    logic [CW-1:0] accn_reg, candn_reg;

    logic [CW-1:0]     k_eff, ld0;
    logic [LW-1:0]     len_eff;
    logic [PW-1:0]     pos0;
    logic [VNUM_W-1:0] vc0;
    logic              accept, storing, last;

    assign accept = item_valid && adv;

    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
        begin
            k_eff = CW'(MAX_CLUSTERS);
        end
        else
        begin
            k_eff = CW'(cluster_count_reg);
        end

        if (vector_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (32'(vector_length_reg) > MAX_LENGTH)
        begin
            len_eff = LW'(MAX_LENGTH);
        end
        else
        begin
            len_eff = LW'(vector_length_reg);
        end

        pos0    = item.start_set ? '0 : position_reg;
        vc0     = item.start_set ? '0 : count_reg;
        ld0     = item.start_set ? '0 : loaded_reg;
        storing = ld0 < k_eff;
        last    = (32'(pos0) + 32'd1) >= 32'(len_eff);

        position_next = position_reg;
        count_next    = count_reg;
        loaded_next   = loaded_reg;
        if (accept)
        begin
            if (last)
            begin
                position_next = '0;
                count_next    = VNUM_W'(32'(vc0) + 32'd1);
                loaded_next   = storing ? CW'(32'(ld0) + 32'd1) : ld0;
            end
            else
            begin
                position_next = PW'(32'(pos0) + 32'd1);
                count_next    = vc0;
                loaded_next   = ld0;
            end
        end

        tok_next.valid   = accept;
        tok_next.first   = (pos0 == '0);
        tok_next.last    = last;
        tok_next.store   = storing;
        tok_next.feature = item.feature_value;
        tok_next.vnum    = vc0;
        tok_next.best_d  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CLUSTER_COUNT_RST;
            vector_length_reg <= VECTOR_LENGTH_RST;
        end
        else if (write_enable)
        begin
            case (write_index)
                CFG_CLUSTER_COUNT: cluster_count_reg <= write_data[CLUSTER_COUNT_W-1:0];
                CFG_VECTOR_LENGTH: vector_length_reg <= write_data[VECTOR_LENGTH_W-1:0];
                default:           cluster_count_reg <= cluster_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
            loaded_reg   <= '0;
            tok_reg      <= '0;
        end
        else if (adv)
        begin
            position_reg <= position_next;
            count_reg    <= count_next;
            loaded_reg   <= loaded_next;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg   <= pos0;
            sidx_reg  <= IW'(ld0);
            accn_reg  <= storing ? ld0 : k_eff;
            candn_reg <= storing ? CW'(32'(ld0) + 32'd1) : k_eff;
        end
    end

    assign tok   = tok_reg;
    assign pos   = pos_reg;
    assign sidx  = sidx_reg;
    assign accn  = accn_reg;
    assign candn = candn_reg;

endmodule

// ===== hdl/nca_cell.sv =====
// One centroid cell: holds a centroid, accumulates its distance, keeps the running best.
`timescale 1ns / 1ps

module nca_cell
    import nca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
    parameter int CELL_INDEX   = 0,
    localparam int CW = $clog2(MAX_CLUSTERS + 1),
    localparam int IW = $clog2(MAX_CLUSTERS),
    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  token_t        tok_in,
    input  logic [PW-1:0] pos_in,
    input  logic [IW-1:0] sidx_in,
    input  logic [CW-1:0] accn_in,
    input  logic [CW-1:0] candn_in,
    input  logic [IW-1:0] bidx_in,
    output token_t        tok_out,
    output logic [PW-1:0] pos_out,
    output logic [IW-1:0] sidx_out,
    output logic [CW-1:0] accn_out,
    output logic [CW-1:0] candn_out,
    output logic [IW-1:0] bidx_out
);

    logic              here_store, here_acc;
    logic [FEAT_W-1:0] cent_data;

    token_t        tok1_reg, tok2_reg, tok3_reg, out_reg, out_next;
    logic          acc1_reg, zero1_reg, acc2_reg, zero2_reg;
    logic [PW-1:0] pos1_reg, pos2_reg, pos3_reg, pos_o_reg;
    logic [IW-1:0] sidx1_reg, sidx2_reg, sidx3_reg, sidx_o_reg;
    logic [CW-1:0] accn1_reg, accn2_reg, accn3_reg, accn_o_reg;
    logic [CW-1:0] cand1_reg, cand2_reg, cand3_reg, cand_o_reg;
    logic [IW-1:0] bidx1_reg, bidx2_reg, bidx3_reg, bidx_o_reg;

    logic signed [FEAT_W:0]     diff;
    logic signed [2*FEAT_W+1:0] prod;
    logic [SQ_W-1:0]            sq2_reg;
    logic [DIST_W-1:0]          sum_reg, sum_next, base;
    logic [DIST_W:0]            sum_wide;
    logic                       take;

    assign here_store = tok_in.valid && tok_in.store && (sidx_in == IW'(CELL_INDEX));
    assign here_acc   = tok_in.valid && (CW'(CELL_INDEX) < accn_in);

    nca_ram #(
        .WIDTH(FEAT_W),
        .DEPTH(MAX_LENGTH)
    ) u_store (
        .clk  (clk),
        .en   (adv),
        .we   (here_store),
        .addr (pos_in),
        .wdata(tok_in.feature),
        .rdata(cent_data)
    );

    assign diff = $signed({tok1_reg.feature[FEAT_W-1], tok1_reg.feature})
                - $signed({cent_data[FEAT_W-1], cent_data});
    assign prod = diff * diff;

    always_comb
    begin
        base     = tok2_reg.first ? '0 : sum_reg;
        sum_wide = {1'b0, base} + (DIST_W + 1)'(sq2_reg);
        if (acc2_reg)
        begin
            sum_next = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
        end
        else if (zero2_reg)
        begin
            sum_next = '0;
        end
        else
        begin
            sum_next = base;
        end
    end

    assign take = (CELL_INDEX == 0)
               || ((CW'(CELL_INDEX) < cand3_reg) && (sum_reg < tok3_reg.best_d));

    always_comb
    begin
        out_next        = tok3_reg;
        out_next.best_d = take ? sum_reg : tok3_reg.best_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg  <= '0;
            tok2_reg  <= '0;
            tok3_reg  <= '0;
            out_reg   <= '0;
            acc1_reg  <= 1'b0;
            zero1_reg <= 1'b0;
            acc2_reg  <= 1'b0;
            zero2_reg <= 1'b0;
            sum_reg   <= '0;
        end
        else if (adv)
        begin
            tok1_reg  <= tok_in;
            acc1_reg  <= here_acc;
            zero1_reg <= here_store;
            tok2_reg  <= tok1_reg;
            acc2_reg  <= acc1_reg;
            zero2_reg <= zero1_reg;
            tok3_reg  <= tok2_reg;
            if (tok2_reg.valid)
            begin
                sum_reg <= sum_next;
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq2_reg    <= prod[SQ_W-1:0];
            pos1_reg   <= pos_in;
            sidx1_reg  <= sidx_in;
            accn1_reg  <= accn_in;
            cand1_reg  <= candn_in;
            bidx1_reg  <= bidx_in;
            pos2_reg   <= pos1_reg;
            sidx2_reg  <= sidx1_reg;
            accn2_reg  <= accn1_reg;
            cand2_reg  <= cand1_reg;
            bidx2_reg  <= bidx1_reg;
            pos3_reg   <= pos2_reg;
            sidx3_reg  <= sidx2_reg;
            accn3_reg  <= accn2_reg;
            cand3_reg  <= cand2_reg;
            bidx3_reg  <= bidx2_reg;
            pos_o_reg  <= pos3_reg;
            sidx_o_reg <= sidx3_reg;
            accn_o_reg <= accn3_reg;
            cand_o_reg <= cand3_reg;
            bidx_o_reg <= take ? IW'(CELL_INDEX) : bidx3_reg;
        end
    end

    assign tok_out   = out_reg;
    assign pos_out   = pos_o_reg;
    assign sidx_out  = sidx_o_reg;
    assign accn_out  = accn_o_reg;
    assign candn_out = cand_o_reg;
    assign bidx_out  = bidx_o_reg;

endmodule

// ===== hdl/nearest_centroid_assigner.sv =====
// A result reaches the output register after the last element of its vector has passed the head and every cell.
// Throughput: one element per cycle when not stalled; each cell spends four stages on every element.
// A result waiting in the output register with ready low holds the whole chain and input ready.
// Reset clears the counts and pipeline valids and sets cluster_count to 2, vector_length to 8;
// centroid memories are not cleared; only cells loaded or loading in the current set are accumulated and compared.
`timescale 1ns / 1ps

module nearest_centroid_assigner
    import nca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_LENGTH   = MAX_LENGTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data
);

    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    token_t        tok   [MAX_CLUSTERS+1];
    logic [PW-1:0] pos   [MAX_CLUSTERS+1];
    logic [IW-1:0] sidx  [MAX_CLUSTERS+1];
    logic [CW-1:0] accn  [MAX_CLUSTERS+1];
    logic [CW-1:0] candn [MAX_CLUSTERS+1];
    logic [IW-1:0] bidx  [MAX_CLUSTERS+1];

    logic    adv;
    logic    result_valid_reg;
    result_t result_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    nca_head #(
        .MAX_CLUSTERS(MAX_CLUSTERS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_head (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_valid  (item_valid),
        .item        (item),
        .write_enable(write_enable),
        .write_index (write_index),
        .write_data  (write_data),
        .tok         (tok[0]),
        .pos         (pos[0]),
        .sidx        (sidx[0]),
        .accn        (accn[0]),
        .candn       (candn[0])
    );

    assign bidx[0] = '0;

    for (genvar c = 0; c < MAX_CLUSTERS; c++)
    begin : g_cell
        nca_cell #(
            .MAX_CLUSTERS(MAX_CLUSTERS),
            .MAX_LENGTH  (MAX_LENGTH),
            .CELL_INDEX  (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .tok_in   (tok[c]),
            .pos_in   (pos[c]),
            .sidx_in  (sidx[c]),
            .accn_in  (accn[c]),
            .candn_in (candn[c]),
            .bidx_in  (bidx[c]),
            .tok_out  (tok[c+1]),
            .pos_out  (pos[c+1]),
            .sidx_out (sidx[c+1]),
            .accn_out (accn[c+1]),
            .candn_out(candn[c+1]),
            .bidx_out (bidx[c+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= tok[MAX_CLUSTERS].valid && tok[MAX_CLUSTERS].last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.cluster_index    <= CIDX_W'(bidx[MAX_CLUSTERS]);
            result_reg.vector_number    <= tok[MAX_CLUSTERS].vnum;
            result_reg.distance_squared <= tok[MAX_CLUSTERS].best_d;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the nearest centroid assigner: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import nca_pkg::*;

    localparam int NUM_CELLS     = MAX_CLUSTERS_DEF;
    localparam int NUM_POS       = MAX_LENGTH_DEF;
    localparam int SETTLE_CYCLES = 4 * MAX_CLUSTERS_DEF + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_e;

    typedef struct packed {
        row_op_e                op;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        item_t                  element;
        logic                   typed;
        result_t                want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    item_t                  item;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   write_enable;
    logic [CFG_INDEX_W-1:0] write_index;
    logic [CFG_DATA_W-1:0]  write_data;

    int cycle_count    = 0;
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    result_t expected_clusters[$];
    dir_row_t dir_rows[$];

    logic [FEAT_W-1:0]          centroid_mem [NUM_CELLS][NUM_POS];
    bit                         entry_written [NUM_CELLS][NUM_POS];
    logic [DIST_W-1:0]          partial_dist [NUM_CELLS];
    int                         elem_pos;
    int                         centroids_held;
    logic [VNUM_W-1:0]          vector_seq;
    logic [CLUSTER_COUNT_W-1:0] cfg_clusters;
    logic [VECTOR_LENGTH_W-1:0] cfg_length;

    nearest_centroid_assigner i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_clusters.size() == 0)
            begin
                report_mismatch("result transfer with no assignment pending");
            end
            else
            begin
                want = expected_clusters.pop_front();
                if (result.cluster_index !== want.cluster_index)
                begin
                    report_mismatch($sformatf("vector %0d: cluster_index %0d, expected %0d",
                        want.vector_number, result.cluster_index, want.cluster_index));
                end
                if (result.vector_number !== want.vector_number)
                begin
                    report_mismatch($sformatf("vector_number %0d, expected %0d",
                        result.vector_number, want.vector_number));
                end
                if (result.distance_squared !== want.distance_squared)
                begin
                    report_mismatch($sformatf("vector %0d: distance_squared %0d, expected %0d",
                        want.vector_number, result.distance_squared, want.distance_squared));
                end
            end
        end
    end

    function automatic int eff_clusters();
        if (cfg_clusters == '0)
        begin
            return 1;
        end
        if (int'(cfg_clusters) > NUM_CELLS)
        begin
            return NUM_CELLS;
        end
        return int'(cfg_clusters);
    endfunction

    function automatic int eff_length();
        if (cfg_length == '0)
        begin
            return 1;
        end
        if (int'(cfg_length) > NUM_POS)
        begin
            return NUM_POS;
        end
        return int'(cfg_length);
    endfunction

    function automatic int cur_pos();
        return (elem_pos >= NUM_POS) ? NUM_POS - 1 : elem_pos;
    endfunction

    function automatic int candidates();
        int k;
        k = eff_clusters();
        return (centroids_held < k) ? centroids_held : k;
    endfunction

    // Elements a fresh set has not yet written must never be compared against.
    function automatic bit reads_unwritten();
        int p;
        int n;
        p = cur_pos();
        n = candidates();
        for (int c = 0; c < n; c++)
        begin
            if (!entry_written[c][p])
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic assign_element(input item_t it, output bit produced, output result_t res);
        int                k;
        int                len;
        int                p;
        int                n;
        int                best;
        bit                storing;
        longint            diff;
        logic [DIST_W:0]   sum;
        logic [DIST_W-1:0] best_d;
        k = eff_clusters();
        len = eff_length();
        produced = 1'b0;
        res = '0;
        if (it.start_set)
        begin
            vector_seq = '0;
            centroids_held = 0;
            elem_pos = 0;
            foreach (entry_written[c, q])
            begin
                entry_written[c][q] = 1'b0;
            end
        end
        p = cur_pos();
        if (p == 0)
        begin
            foreach (partial_dist[c])
            begin
                partial_dist[c] = '0;
            end
        end
        storing = centroids_held < k;
        n = candidates();
        for (int c = 0; c < n; c++)
        begin
            diff = longint'($signed(it.feature_value)) - longint'($signed(centroid_mem[c][p]));
            sum = partial_dist[c];
            sum = sum + (DIST_W+1)'(diff * diff);
            partial_dist[c] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
        end
        if (storing && centroids_held < NUM_CELLS)
        begin
            centroid_mem[centroids_held][p] = it.feature_value;
            entry_written[centroids_held][p] = 1'b1;
            partial_dist[centroids_held] = '0;
        end
        if (p + 1 < len)
        begin
            elem_pos = p + 1;
            return;
        end
        if (storing)
        begin
            n = centroids_held + 1;
        end
        if (n > NUM_CELLS)
        begin
            n = NUM_CELLS;
        end
        best = 0;
        best_d = partial_dist[0];
        for (int c = 1; c < n; c++)
        begin
            if (partial_dist[c] < best_d)
            begin
                best_d = partial_dist[c];
                best = c;
            end
        end
        res.cluster_index = CIDX_W'(best);
        res.vector_number = vector_seq;
        res.distance_squared = best_d;
        if (storing && centroids_held < NUM_CELLS)
        begin
            centroids_held++;
        end
        vector_seq = vector_seq + 1'b1;
        elem_pos = 0;
        produced = 1'b1;
    endtask

    function automatic logic [FEAT_W-1:0] pick_feature(input bit fresh);
        int roll;
        int n;
        int c;
        int p;
        roll = $urandom_range(99);
        n = fresh ? 0 : candidates();
        p = cur_pos();
        if (roll < 10)
        begin
            case ($urandom_range(2))
                0: return 16'h7FFF;
                1: return 16'h8000;
                default: return 16'h0000;
            endcase
        end
        if (roll < 55 && n > 0)
        begin
            c = $urandom_range(n - 1);
            if (entry_written[c][p])
            begin
                return centroid_mem[c][p] + FEAT_W'($urandom_range(6)) - FEAT_W'(3);
            end
        end
        return FEAT_W'($urandom());
    endfunction

    task automatic push_element(input item_t it, input bit typed, input result_t want);
        bit      produced;
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        assign_element(it, produced, predicted);
        if (produced)
        begin
            expected_clusters.insert(expected_clusters.size(), typed ? want : predicted);
        end
    endtask

    task automatic wait_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_clusters.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= data;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == CFG_CLUSTER_COUNT)
        begin
            cfg_clusters = data[CLUSTER_COUNT_W-1:0];
        end
        else
        begin
            cfg_length = data[VECTOR_LENGTH_W-1:0];
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] k_data,
                             input logic [CFG_DATA_W-1:0] len_data,
                             input int idle, input int stall,
                             input int elems, input int start_permille);
        item_t it;
        write_reg(CFG_CLUSTER_COUNT, k_data);
        write_reg(CFG_VECTOR_LENGTH, len_data);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < elems; i++)
        begin
            if (i == elems / 2 || $urandom_range(199) == 0)
            begin
                wait_results();
            end
            it.start_set = (i == 0 && start_permille > 0 && $urandom_range(1) == 1) ||
                           ($urandom_range(999) < start_permille);
            if (!it.start_set && reads_unwritten())
            begin
                it.start_set = 1'b1;
            end
            it.feature_value = pick_feature(it.start_set);
            push_element(it, 1'b0, '0);
        end
    endtask

    function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.op = ROW_WRITE;
        r.index = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t elem_row(input logic [FEAT_W-1:0] feat, input logic start);
        dir_row_t r;
        r = '0;
        r.op = ROW_ITEM;
        r.element.feature_value = feat;
        r.element.start_set = start;
        return r;
    endfunction

    function automatic dir_row_t check_row(input logic [FEAT_W-1:0] feat, input logic start,
                                           input result_t want);
        dir_row_t r;
        r = elem_row(feat, start);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    initial
    begin
        item_valid <= 1'b0;
        item <= '0;
        write_enable <= 1'b0;
        write_index <= '0;
        write_data <= '0;
        rst_n <= 1'b0;
        foreach (entry_written[c, q])
        begin
            entry_written[c][q] = 1'b0;
        end
        foreach (partial_dist[c])
        begin
            partial_dist[c] = '0;
        end
        elem_pos = 0;
        centroids_held = 0;
        vector_seq = '0;
        cfg_clusters = CLUSTER_COUNT_RST;
        cfg_length = VECTOR_LENGTH_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            cfg_row(CFG_VECTOR_LENGTH, 7'd2),
            cfg_row(CFG_CLUSTER_COUNT, 7'd2),
            elem_row(16'h7FFF, 1'b1),
            check_row(16'h8000, 1'b0, {4'd0, 16'd0, 40'd0}),
            elem_row(16'h8000, 1'b0),
            check_row(16'h7FFF, 1'b0, {4'd1, 16'd1, 40'd0}),
            elem_row(16'h8000, 1'b0),
            check_row(16'h7FFF, 1'b0, {4'd1, 16'd2, 40'd0}),
            elem_row(16'h0000, 1'b0),
            check_row(16'h0000, 1'b0, {4'd0, 16'd3, 40'd2147418113}),
            cfg_row(CFG_CLUSTER_COUNT, 7'd0),
            elem_row(16'h0001, 1'b0),
            elem_row(16'h0001, 1'b0),
            cfg_row(CFG_CLUSTER_COUNT, 7'd31),
            elem_row(16'h0005, 1'b0),
            cfg_row(CFG_CLUSTER_COUNT, 7'd2),
            elem_row(16'h0007, 1'b0),
            elem_row(16'h0014, 1'b0),
            cfg_row(CFG_CLUSTER_COUNT, 7'd3),
            check_row(16'h0015, 1'b0, {4'd2, 16'd6, 40'd0}),
            elem_row(16'h0003, 1'b0),
            cfg_row(CFG_VECTOR_LENGTH, 7'd0),
            elem_row(16'h0004, 1'b0),
            elem_row(16'hFFFF, 1'b0),
            cfg_row(CFG_VECTOR_LENGTH, 7'd2),
            elem_row(16'h0064, 1'b1),
            elem_row(16'h00C8, 1'b1),
            check_row(16'h012C, 1'b0, {4'd0, 16'd0, 40'd0})
        };
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_WRITE)
            begin
                write_reg(dir_rows[i].index, dir_rows[i].data);
            end
            else
            begin
                push_element(dir_rows[i].element, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        run_phase(7'd4, 7'd3, 0, 0, 200, 20);
        run_phase(7'd16, 7'd1, 49, 0, 200, 15);
        run_phase(7'd1, 7'd5, 0, 49, 150, 20);
        run_phase(7'd2, 7'd127, 18, 18, 260, 0);
        run_phase(7'd16, 7'd2, 18, 18, 200, 10);
        run_phase(7'd127, 7'd4, 49, 0, 190, 10);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
